// File: hw/rtl/rsi_pkg.sv
package rsi_pkg;

  localparam int MAX_SQUARES = 16;
  localparam int IDX_W       = $clog2(MAX_SQUARES);
  localparam int CNT_W       = 5;
  localparam int VEC_W       = 32;
  localparam int ROW_W       = 3 * VEC_W;

  localparam logic signed [31:0] MIN_T = 32'sd6554;

  localparam logic [2:0] OP_LOAD_CENTER = 3'd0;
  localparam logic [2:0] OP_LOAD_NORMAL = 3'd1;
  localparam logic [2:0] OP_LOAD_SIZE   = 3'd2;
  localparam logic [2:0] OP_SET_ORIGIN  = 3'd3;
  localparam logic [2:0] OP_NEAREST     = 3'd4;
  localparam logic [2:0] OP_SHADOW      = 3'd5;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [3:0]         slot;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] bound_dist;
  } ray_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_distance;
    logic [3:0]         hit_index;
  } ray_out_t;

  // shared divide / square root unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [63:0] num;
    logic [63:0] dvs;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } unit_rsp_t;

endpackage

// File: hw/rtl/ray_square_intersect.sv
// Load and origin transactions are handled without leaving the idle state, so the block stays ready.
// A trace checks the squares one after another: each square uses at most
// six 64-step divides and three 32-step square roots on one shared unit, plus
// at most twenty-one products on one 33x33 multiplier.
// The result sits in an output register; a new transaction is taken while it waits.
// Reset (synchronous, rst high) clears square_count, the ray origin and control state.
module ray_square_intersect (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rsi_pkg::ray_in_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output rsi_pkg::ray_out_t out_item,
  input  logic             cfg_we,
  input  logic [rsi_pkg::CNT_W-1:0] cfg_data
);

  typedef enum logic [25:0] {
    ST_IDLE     = 26'd1 << 0,
    ST_READ     = 26'd1 << 1,
    ST_LEN_MUL  = 26'd1 << 2,
    ST_LEN_ACC  = 26'd1 << 3,
    ST_LEN_SQRT = 26'd1 << 4,
    ST_NRM_DIV  = 26'd1 << 5,
    ST_DEN_MUL  = 26'd1 << 6,
    ST_DEN_ACC  = 26'd1 << 7,
    ST_NUM_MUL  = 26'd1 << 8,
    ST_NUM_ACC  = 26'd1 << 9,
    ST_T_DIV    = 26'd1 << 10,
    ST_GL_MUL   = 26'd1 << 11,
    ST_GL_ACC   = 26'd1 << 12,
    ST_GL_SQRT  = 26'd1 << 13,
    ST_U_DIV    = 26'd1 << 14,
    ST_IP_MUL   = 26'd1 << 15,
    ST_IP_ACC   = 26'd1 << 16,
    ST_IP2_MUL  = 26'd1 << 17,
    ST_IP2_ACC  = 26'd1 << 18,
    ST_A_MUL    = 26'd1 << 19,
    ST_A_ACC    = 26'd1 << 20,
    ST_A2_MUL   = 26'd1 << 21,
    ST_B_PREP   = 26'd1 << 22,
    ST_B_SQRT   = 26'd1 << 23,
    ST_CHECK    = 26'd1 << 24,
    ST_OUT      = 26'd1 << 25
  } state_t;

  function automatic logic signed [31:0] comp(input logic [rsi_pkg::ROW_W-1:0] row,
                                              input logic [1:0] sel);
    case (sel)
      2'd0:    return row[31:0];
      2'd1:    return row[63:32];
      default: return row[95:64];
    endcase
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // divide by 65536, truncating toward zero
  function automatic logic signed [49:0] tr16(input logic signed [65:0] v);
    logic signed [65:0] w;
    w = v + (v[65] ? 66'sd65535 : 66'sd0);
    return 50'(w >>> 16);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) return 32'sh7fffffff;
    if (v < -51'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  state_t state;
  logic [1:0] k;
  logic [rsi_pkg::IDX_W-1:0] idx;
  logic [rsi_pkg::CNT_W-1:0] count;
  logic [rsi_pkg::CNT_W-1:0] square_count;
  logic shadow;
  logic found;
  logic signed [31:0] best;
  logic [rsi_pkg::IDX_W-1:0] best_idx;
  logic signed [31:0] dir [3];
  logic signed [31:0] org [3];
  logic signed [17:0] nrm [3];
  logic signed [17:0] uax [3];
  logic signed [31:0] ip  [3];
  logic signed [65:0] prod;
  logic signed [65:0] acc;
  logic [32:0] len;
  logic [31:0] gl;
  logic signed [35:0] den;
  logic signed [31:0] t;
  logic [63:0] ip2;
  logic [31:0] ma;
  logic [31:0] bsq;
  logic launched;

  logic [rsi_pkg::ROW_W-1:0] c_rd, n_rd;
  logic [31:0] s_rd;
  logic accept;
  logic slot_ok;
  logic [rsi_pkg::CNT_W-1:0] clamp;
  logic last;

  logic signed [31:0] nk, ck, ok_v, dk, nx, nz;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] sum_next;
  logic signed [49:0] den_full, a_full;
  logic [49:0] a_mag;
  logic [31:0] ma_val;
  logic signed [31:0] ip_val;
  logic [65:0] acc_mag;
  logic [35:0] den_mag;
  logic [63:0] q;
  logic q_neg;
  logic signed [17:0] q18;
  logic signed [31:0] t_val;
  logic [31:0] m;
  logic qual;
  logic unit_state;

  rsi_pkg::unit_req_t req;
  rsi_pkg::unit_rsp_t rsp;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign slot_ok  = (32'(in_item.slot) < rsi_pkg::MAX_SQUARES);
  assign clamp    = (32'(square_count) > rsi_pkg::MAX_SQUARES) ?
                    rsi_pkg::CNT_W'(rsi_pkg::MAX_SQUARES) : square_count;
  assign last     = (rsi_pkg::CNT_W'(idx) + rsi_pkg::CNT_W'(1)) == count;

  rsi_ram #(.WIDTH(rsi_pkg::ROW_W), .DEPTH(rsi_pkg::MAX_SQUARES)) u_center (
    .clk   (clk),
    .we    (accept && in_item.opcode == rsi_pkg::OP_LOAD_CENTER && slot_ok),
    .waddr (in_item.slot[rsi_pkg::IDX_W-1:0]),
    .wdata ({in_item.vec_z, in_item.vec_y, in_item.vec_x}),
    .raddr (idx),
    .rdata (c_rd)
  );

  rsi_ram #(.WIDTH(rsi_pkg::ROW_W), .DEPTH(rsi_pkg::MAX_SQUARES)) u_normal (
    .clk   (clk),
    .we    (accept && in_item.opcode == rsi_pkg::OP_LOAD_NORMAL && slot_ok),
    .waddr (in_item.slot[rsi_pkg::IDX_W-1:0]),
    .wdata ({in_item.vec_z, in_item.vec_y, in_item.vec_x}),
    .raddr (idx),
    .rdata (n_rd)
  );

  rsi_ram #(.WIDTH(rsi_pkg::VEC_W), .DEPTH(rsi_pkg::MAX_SQUARES)) u_size (
    .clk   (clk),
    .we    (accept && in_item.opcode == rsi_pkg::OP_LOAD_SIZE && slot_ok),
    .waddr (in_item.slot[rsi_pkg::IDX_W-1:0]),
    .wdata (in_item.vec_x),
    .raddr (idx),
    .rdata (s_rd)
  );

  rsi_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign nk   = comp(n_rd, k);
  assign ck   = comp(c_rd, k);
  assign nx   = comp(n_rd, 2'd0);
  assign nz   = comp(n_rd, 2'd2);
  assign ok_v = org[k];
  assign dk   = dir[k];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_LEN_MUL, ST_GL_MUL: begin
        mul_a = 33'(nk);
        mul_b = 33'(nk);
      end
      ST_DEN_MUL: begin
        mul_a = 33'(nrm[k]);
        mul_b = 33'(dk);
      end
      ST_NUM_MUL: begin
        mul_a = 33'(ck) - 33'(ok_v);
        mul_b = 33'(nrm[k]);
      end
      ST_IP_MUL: begin
        mul_a = 33'(t);
        mul_b = 33'(dk);
      end
      ST_IP2_MUL: begin
        mul_a = 33'(ip[k]);
        mul_b = 33'(ip[k]);
      end
      ST_A_MUL: begin
        mul_a = 33'(ip[k]);
        mul_b = 33'(uax[k]);
      end
      ST_A2_MUL: begin
        mul_a = $signed({1'b0, ma});
        mul_b = $signed({1'b0, ma});
      end
      default: ;
    endcase
  end

  assign sum_next = ((k == 2'd0) ? 66'sd0 : acc) + prod;
  assign den_full = tr16(sum_next);
  assign a_full   = tr16(sum_next);
  assign a_mag    = a_full[49] ? 50'(-a_full) : a_full;
  assign ma_val   = (|a_mag[49:32]) ? 32'hffff_ffff : a_mag[31:0];
  assign ip_val   = sat32(51'(ok_v) - 51'(ck) + 51'(tr16(prod)));
  assign acc_mag  = acc[65] ? 66'(-acc) : acc;
  assign den_mag  = den[35] ? 36'(-den) : den;

  assign unit_state = (state == ST_LEN_SQRT) || (state == ST_NRM_DIV) ||
                      (state == ST_T_DIV) || (state == ST_GL_SQRT) ||
                      (state == ST_U_DIV) || (state == ST_B_SQRT);

  always_comb begin
    req.start   = unit_state && !launched;
    req.is_sqrt = 1'b0;
    req.num     = '0;
    req.dvs     = 64'd1;
    q_neg       = 1'b0;
    case (state)
      ST_LEN_SQRT, ST_GL_SQRT, ST_B_SQRT: begin
        req.is_sqrt = 1'b1;
        req.num     = acc[63:0];
      end
      ST_NRM_DIV: begin
        req.num = {16'd0, mag32(nk), 16'd0};
        req.dvs = {31'd0, len};
        q_neg   = nk[31];
      end
      ST_T_DIV: begin
        req.num = acc_mag[63:0];
        req.dvs = {28'd0, den_mag};
        q_neg   = acc[65] ^ den[35];
      end
      ST_U_DIV: begin
        if (k == 2'd0) begin
          req.num = {16'd0, mag32(nz), 16'd0};
          q_neg   = !nz[31];
        end else begin
          req.num = {16'd0, mag32(nx), 16'd0};
          q_neg   = nx[31];
        end
        req.dvs = {32'd0, gl};
      end
      default: ;
    endcase
  end

  assign q   = rsp.res;
  assign q18 = q_neg ? -$signed(q[17:0]) : $signed(q[17:0]);

  always_comb begin
    if (!q_neg) begin
      t_val = (q > 64'h7fff_ffff) ? 32'sh7fffffff : $signed(q[31:0]);
    end else begin
      t_val = (q > 64'h8000_0000) ? 32'sh80000000 : -$signed(q[31:0]);
    end
  end

  assign m    = (ma > bsq) ? ma : bsq;
  assign qual = !s_rd[31] && ({m, 1'b0} <= {1'b0, s_rd}) && (t >= rsi_pkg::MIN_T) &&
                (t < best);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state        <= ST_IDLE;
      launched     <= 1'b0;
      out_valid    <= 1'b0;
      square_count <= '0;
      idx          <= '0;
      k            <= '0;
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        square_count <= cfg_data;
      end
      if (rsp.done) begin
        launched <= 1'b0;
      end else if (req.start) begin
        launched <= 1'b1;
      end
      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_item.opcode)
              rsi_pkg::OP_SET_ORIGIN: begin
                org[0] <= in_item.vec_x;
                org[1] <= in_item.vec_y;
                org[2] <= in_item.vec_z;
              end
              rsi_pkg::OP_NEAREST, rsi_pkg::OP_SHADOW: begin
                dir[0]   <= in_item.vec_x;
                dir[1]   <= in_item.vec_y;
                dir[2]   <= in_item.vec_z;
                best     <= in_item.bound_dist;
                best_idx <= '0;
                shadow   <= (in_item.opcode == rsi_pkg::OP_SHADOW);
                found    <= 1'b0;
                idx      <= '0;
                k        <= '0;
                count    <= clamp;
                state    <= (clamp == '0) ? ST_OUT : ST_READ;
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          k     <= '0;
          state <= ST_LEN_MUL;
        end
        ST_LEN_MUL: state <= ST_LEN_ACC;
        ST_LEN_ACC: begin
          acc <= sum_next;
          if (k == 2'd2) begin
            k     <= '0;
            state <= ST_LEN_SQRT;
          end else begin
            k     <= k + 2'd1;
            state <= ST_LEN_MUL;
          end
        end
        ST_LEN_SQRT: begin
          if (rsp.done) begin
            len <= q[32:0];
            if (q == 64'd0) begin
              if (last) begin
                state <= ST_OUT;
              end else begin
                idx   <= idx + rsi_pkg::IDX_W'(1);
                state <= ST_READ;
              end
            end else begin
              state <= ST_NRM_DIV;
            end
          end
        end
        ST_NRM_DIV: begin
          if (rsp.done) begin
            nrm[k] <= q18;
            if (k == 2'd2) begin
              k     <= '0;
              state <= ST_DEN_MUL;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        ST_DEN_MUL: state <= ST_DEN_ACC;
        ST_DEN_ACC: begin
          acc <= sum_next;
          if (k == 2'd2) begin
            k   <= '0;
            den <= den_full[35:0];
            if (den_full == '0) begin
              if (last) begin
                state <= ST_OUT;
              end else begin
                idx   <= idx + rsi_pkg::IDX_W'(1);
                state <= ST_READ;
              end
            end else begin
              state <= ST_NUM_MUL;
            end
          end else begin
            k     <= k + 2'd1;
            state <= ST_DEN_MUL;
          end
        end
        ST_NUM_MUL: state <= ST_NUM_ACC;
        ST_NUM_ACC: begin
          acc <= sum_next;
          if (k == 2'd2) begin
            k     <= '0;
            state <= ST_T_DIV;
          end else begin
            k     <= k + 2'd1;
            state <= ST_NUM_MUL;
          end
        end
        ST_T_DIV: begin
          if (rsp.done) begin
            t <= t_val;
            k <= '0;
            if (nx == '0 && nz == '0) begin
              uax[0] <= '0;
              uax[1] <= '0;
              uax[2] <= 18'sd65536;
              state  <= ST_IP_MUL;
            end else begin
              state <= ST_GL_MUL;
            end
          end
        end
        ST_GL_MUL: state <= ST_GL_ACC;
        ST_GL_ACC: begin
          acc <= sum_next;
          if (k == 2'd2) begin
            k     <= '0;
            state <= ST_GL_SQRT;
          end else begin
            k     <= 2'd2;
            state <= ST_GL_MUL;
          end
        end
        ST_GL_SQRT: begin
          if (rsp.done) begin
            gl    <= q[31:0];
            state <= ST_U_DIV;
          end
        end
        ST_U_DIV: begin
          if (rsp.done) begin
            uax[k] <= q18;
            uax[1] <= '0;
            if (k == 2'd2) begin
              k     <= '0;
              state <= ST_IP_MUL;
            end else begin
              k <= 2'd2;
            end
          end
        end
        ST_IP_MUL: state <= ST_IP_ACC;
        ST_IP_ACC: begin
          ip[k] <= ip_val;
          if (k == 2'd2) begin
            k     <= '0;
            state <= ST_IP2_MUL;
          end else begin
            k     <= k + 2'd1;
            state <= ST_IP_MUL;
          end
        end
        ST_IP2_MUL: state <= ST_IP2_ACC;
        ST_IP2_ACC: begin
          acc <= sum_next;
          if (k == 2'd2) begin
            k     <= '0;
            ip2   <= sum_next[63:0];
            state <= ST_A_MUL;
          end else begin
            k     <= k + 2'd1;
            state <= ST_IP2_MUL;
          end
        end
        ST_A_MUL: state <= ST_A_ACC;
        ST_A_ACC: begin
          acc <= sum_next;
          if (k == 2'd2) begin
            k     <= '0;
            ma    <= ma_val;
            state <= ST_A2_MUL;
          end else begin
            k     <= k + 2'd1;
            state <= ST_A_MUL;
          end
        end
        ST_A2_MUL: state <= ST_B_PREP;
        ST_B_PREP: begin
          acc   <= (ip2 > prod[63:0]) ? 66'(ip2 - prod[63:0]) : 66'sd0;
          state <= ST_B_SQRT;
        end
        ST_B_SQRT: begin
          if (rsp.done) begin
            bsq   <= q[31:0];
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (qual) begin
            found <= 1'b1;
            if (!shadow) begin
              best     <= t;
              best_idx <= idx;
            end
          end
          if ((qual && shadow) || last) begin
            state <= ST_OUT;
          end else begin
            idx   <= idx + rsi_pkg::IDX_W'(1);
            state <= ST_READ;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_item.hit          <= found;
            out_item.hit_distance <= shadow ? 32'sd0 : best;
            out_item.hit_index    <= shadow ? 4'd0 : 4'(best_idx);
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/rsi_ram.sv
module rsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rsi_unit.sv
module rsi_unit (
  input  logic              clk,
  input  logic              rst,
  input  rsi_pkg::unit_req_t req,
  output rsi_pkg::unit_rsp_t rsp
);

  logic [64:0] acc;
  logic [63:0] q;
  logic [63:0] b;
  logic [5:0]  cnt;
  logic        busy;
  logic        is_sqrt;
  logic        done;

  logic [64:0] sh;
  logic [63:0] rb;

  assign sh = {acc[63:0], q[63]};
  assign rb = q + b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        is_sqrt <= req.is_sqrt;
        if (req.is_sqrt) begin
          acc <= {1'b0, req.num};
          q   <= '0;
          b   <= 64'h4000_0000_0000_0000;
          cnt <= 6'd31;
        end else begin
          acc <= '0;
          q   <= req.num;
          b   <= req.dvs;
          cnt <= 6'd63;
        end
      end else if (busy) begin
        if (is_sqrt) begin
          if (acc[63:0] >= rb) begin
            acc <= acc - {1'b0, rb};
            q   <= (q >> 1) + b;
          end else begin
            q <= q >> 1;
          end
          b <= b >> 2;
        end else begin
          if (sh >= {1'b0, b}) begin
            acc <= sh - {1'b0, b};
            q   <= {q[62:0], 1'b1};
          end else begin
            acc <= sh;
            q   <= {q[62:0], 1'b0};
          end
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = q;

endmodule

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int ONE_Q = 65536;
  localparam int STALL_LIMIT = 60000;
  localparam int TOTAL_ITEMS = 1150;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_we;
  rsi_pkg::ray_in_t in_item;
  rsi_pkg::ray_out_t out_item;
  logic [rsi_pkg::CNT_W-1:0] cfg_data;

  ray_square_intersect dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // scene mirror used for prediction
  logic signed [31:0] ctr_tab [rsi_pkg::MAX_SQUARES*3];
  logic signed [31:0] nrm_tab [rsi_pkg::MAX_SQUARES*3];
  logic signed [31:0] size_tab [rsi_pkg::MAX_SQUARES];
  logic signed [31:0] eye [3];
  int unsigned count_reg;

  // stimulus-side copy of centers and origin, for aiming rays
  longint aim_ctr [rsi_pkg::MAX_SQUARES*3];
  longint aim_eye [3];

  rsi_pkg::ray_in_t pend_q[$];
  rsi_pkg::ray_out_t hit_q[$];
  int errors = 0;
  int sent = 0;
  bit calm = 0;
  bit in_took, out_took;
  int in_gap, out_stall;
  int idle_cycles = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absv(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit square_hit(input int s, input longint d [3], input longint lim,
                                    output longint t_hit);
    longint nv [3], un [3], gu [3], ip [3];
    longint den, num, t, a;
    longint unsigned len, gl, ip2, ma, a2, b2, b, m;
    t_hit = 0;
    len = 0;
    for (int i = 0; i < 3; i++) begin
      nv[i] = longint'(nrm_tab[s*3+i]);
      len += absv(nv[i]) * absv(nv[i]);
    end
    len = root64(len);
    if (len == 0) return 0;
    for (int i = 0; i < 3; i++) un[i] = nv[i] * ONE_Q / $signed(len);
    den = 0;
    num = 0;
    for (int i = 0; i < 3; i++) begin
      den += un[i] * d[i];
      num += (longint'(ctr_tab[s*3+i]) - longint'(eye[i])) * un[i];
    end
    den = den / ONE_Q;
    if (den == 0) return 0;
    t = clip32(num / den);
    if (nv[0] == 0 && nv[2] == 0) begin
      gu[0] = 0; gu[1] = 0; gu[2] = ONE_Q;
    end else begin
      gl = root64(absv(nv[0]) * absv(nv[0]) + absv(nv[2]) * absv(nv[2]));
      gu[0] = -nv[2] * ONE_Q / $signed(gl);
      gu[1] = 0;
      gu[2] = nv[0] * ONE_Q / $signed(gl);
    end
    ip2 = 0;
    a = 0;
    for (int i = 0; i < 3; i++) begin
      ip[i] = clip32((longint'(eye[i]) - longint'(ctr_tab[s*3+i])) + t * d[i] / ONE_Q);
      ip2 += absv(ip[i]) * absv(ip[i]);
      a += ip[i] * gu[i];
    end
    a = a / ONE_Q;
    ma = absv(a);
    if (ma > 64'hFFFF_FFFF) ma = 64'hFFFF_FFFF;
    a2 = ma * ma;
    b2 = (ip2 > a2) ? ip2 - a2 : 0;
    b = root64(b2);
    m = (ma > b) ? ma : b;
    if (size_tab[s] < 0) return 0;
    if (2 * m > longint'(size_tab[s])) return 0;
    if (t < longint'(rsi_pkg::MIN_T) || t >= lim) return 0;
    t_hit = t;
    return 1;
  endfunction

  task automatic apply_item(input rsi_pkg::ray_in_t it);
    longint d [3];
    longint best, t;
    int n, best_idx;
    bit found;
    rsi_pkg::ray_out_t r;
    case (it.opcode)
      rsi_pkg::OP_LOAD_CENTER: begin
        ctr_tab[it.slot*3] = it.vec_x;
        ctr_tab[it.slot*3+1] = it.vec_y;
        ctr_tab[it.slot*3+2] = it.vec_z;
      end
      rsi_pkg::OP_LOAD_NORMAL: begin
        nrm_tab[it.slot*3] = it.vec_x;
        nrm_tab[it.slot*3+1] = it.vec_y;
        nrm_tab[it.slot*3+2] = it.vec_z;
      end
      rsi_pkg::OP_LOAD_SIZE: size_tab[it.slot] = it.vec_x;
      rsi_pkg::OP_SET_ORIGIN: begin
        eye[0] = it.vec_x;
        eye[1] = it.vec_y;
        eye[2] = it.vec_z;
      end
      rsi_pkg::OP_NEAREST, rsi_pkg::OP_SHADOW: begin
        d[0] = longint'(it.vec_x);
        d[1] = longint'(it.vec_y);
        d[2] = longint'(it.vec_z);
        best = longint'(it.bound_dist);
        best_idx = 0;
        found = 0;
        n = (count_reg > rsi_pkg::MAX_SQUARES) ? rsi_pkg::MAX_SQUARES : count_reg;
        for (int s = 0; s < n; s++) begin
          if (square_hit(s, d, best, t)) begin
            found = 1;
            if (it.opcode == rsi_pkg::OP_SHADOW) break;
            best = t;
            best_idx = s;
          end
        end
        r.hit = found;
        r.hit_distance = (it.opcode == rsi_pkg::OP_NEAREST) ? best[31:0] : '0;
        r.hit_index = (it.opcode == rsi_pkg::OP_NEAREST) ? best_idx[3:0] : '0;
        hit_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
      in_item <= '0;
      out_ready <= 0;
      in_gap = 0;
      out_stall = 0;
    end else begin
      if (!(in_valid && !in_took)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 0;
        end else if (pend_q.size() > 0) begin
          in_item <= pend_q.pop_front();
          in_valid <= 1;
          in_gap = calm ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid <= 0;
        end
      end
      if (out_took) out_stall = calm ? 0 : $urandom_range(0, 7);
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsi_pkg::ray_out_t want;
    in_took <= !rst && in_valid && in_ready;
    out_took <= !rst && out_valid && out_ready;
    if (!rst) begin
      if (in_valid && in_ready) apply_item(in_item);
      if (out_valid && out_ready) begin
        if (hit_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %p", $realtime, out_item);
          errors++;
        end else begin
          want = hit_q.pop_front();
          if (out_item.hit !== want.hit)
            $display("%0t hit: expected %0d actual %0d", $realtime, want.hit, out_item.hit);
          if (out_item.hit_distance !== want.hit_distance)
            $display("%0t hit_distance: expected %0d actual %0d", $realtime,
                     want.hit_distance, out_item.hit_distance);
          if (out_item.hit_index !== want.hit_index)
            $display("%0t hit_index: expected %0d actual %0d", $realtime,
                     want.hit_index, out_item.hit_index);
          if (out_item !== want) errors++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  function automatic rsi_pkg::ray_in_t mk(input logic [2:0] op, input int sl, input int x,
                                          input int y, input int z, input int bd);
    rsi_pkg::ray_in_t it;
    it.opcode = op;
    it.slot = sl[3:0];
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    it.bound_dist = bd;
    return it;
  endfunction

  task automatic post(input rsi_pkg::ray_in_t it);
    if (it.opcode == rsi_pkg::OP_LOAD_CENTER) begin
      aim_ctr[it.slot*3] = it.vec_x;
      aim_ctr[it.slot*3+1] = it.vec_y;
      aim_ctr[it.slot*3+2] = it.vec_z;
    end
    if (it.opcode == rsi_pkg::OP_SET_ORIGIN) begin
      aim_eye[0] = it.vec_x;
      aim_eye[1] = it.vec_y;
      aim_eye[2] = it.vec_z;
    end
    pend_q.push_back(it);
    sent++;
  endtask

  function automatic int near_val(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic random_square(input int sl);
    int k, sz;
    post(mk(rsi_pkg::OP_LOAD_CENTER, sl, near_val(1 << 19), near_val(1 << 19),
            near_val(1 << 19), 0));
    k = $urandom_range(0, 9);
    if (k < 4) begin
      case ($urandom_range(0, 2))
        0: post(mk(rsi_pkg::OP_LOAD_NORMAL, sl, ($urandom_range(0, 1) ? 1 : -1) * ONE_Q,
                   0, 0, 0));
        1: post(mk(rsi_pkg::OP_LOAD_NORMAL, sl, 0, ($urandom_range(0, 1) ? 1 : -1) * ONE_Q,
                   0, 0));
        default: post(mk(rsi_pkg::OP_LOAD_NORMAL, sl, 0, 0,
                         ($urandom_range(0, 1) ? 1 : -1) * ONE_Q, 0));
      endcase
    end else if (k < 8) begin
      post(mk(rsi_pkg::OP_LOAD_NORMAL, sl, near_val(1 << 17), near_val(1 << 17),
              near_val(1 << 17), 0));
    end else if (k == 8) begin
      post(mk(rsi_pkg::OP_LOAD_NORMAL, sl, 0, 0, 0, 0));
    end else begin
      post(mk(rsi_pkg::OP_LOAD_NORMAL, sl, $urandom, $urandom, $urandom, $urandom));
    end
    k = $urandom_range(0, 9);
    case (k)
      0: sz = 0;
      1: sz = -int'($urandom_range(1, 1 << 20));
      2: sz = 32'h7fff_ffff;
      3: sz = $urandom;
      default: sz = $urandom_range(1 << 16, 1 << 21);
    endcase
    post(mk(rsi_pkg::OP_LOAD_SIZE, sl, sz, $urandom, $urandom, $urandom));
  endtask

  task automatic random_trace(input int n);
    int s, bd, dx, dy, dz;
    logic [2:0] op;
    op = $urandom_range(0, 1) ? rsi_pkg::OP_NEAREST : rsi_pkg::OP_SHADOW;
    s = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, rsi_pkg::MAX_SQUARES - 1);
    if ($urandom_range(0, 7) == 0) begin
      dx = $urandom; dy = $urandom; dz = $urandom;
    end else begin
      dx = int'(aim_ctr[s*3] - aim_eye[0]) + near_val(1 << 14);
      dy = int'(aim_ctr[s*3+1] - aim_eye[1]) + near_val(1 << 14);
      dz = int'(aim_ctr[s*3+2] - aim_eye[2]) + near_val(1 << 14);
    end
    case ($urandom_range(0, 7))
      0: bd = $urandom;
      1: bd = -int'($urandom_range(0, 1 << 20));
      2: bd = $urandom_range(0, 1 << 18);
      default: bd = 32'h7fff_ffff;
    endcase
    post(mk(op, $urandom, dx, dy, dz, bd));
  endtask

  task automatic wait_idle();
    while (pend_q.size() != 0 || in_valid || hit_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_count(input int v);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1;
    cfg_data <= v[rsi_pkg::CNT_W-1:0];
    @(negedge clk);
    cfg_we <= 0;
    count_reg = v;
  endtask

  initial begin
    int n, k;
    rst = 1;
    cfg_we = 0;
    cfg_data = '0;
    count_reg = 0;
    for (int i = 0; i < rsi_pkg::MAX_SQUARES * 3; i++) begin
      ctr_tab[i] = 0; nrm_tab[i] = 0; aim_ctr[i] = 0;
    end
    for (int i = 0; i < rsi_pkg::MAX_SQUARES; i++) size_tab[i] = 0;
    for (int i = 0; i < 3; i++) begin
      eye[i] = 0; aim_eye[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: square at z=5 facing z, hit exactly at its center
    set_count(2);
    post(mk(rsi_pkg::OP_LOAD_CENTER, 0, 0, 0, 5 * ONE_Q, 0));
    post(mk(rsi_pkg::OP_LOAD_NORMAL, 0, 0, 0, ONE_Q, 0));
    post(mk(rsi_pkg::OP_LOAD_SIZE, 0, 0, 0, 0, 0));
    post(mk(rsi_pkg::OP_LOAD_CENTER, 15, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0));
    post(mk(rsi_pkg::OP_LOAD_CENTER, 1, 0, 0, 3 * ONE_Q, 0));
    post(mk(rsi_pkg::OP_LOAD_NORMAL, 1, 0, 0, 0, 0));
    post(mk(rsi_pkg::OP_LOAD_SIZE, 1, ONE_Q, 0, 0, 0));
    post(mk(rsi_pkg::OP_NEAREST, 0, 0, 0, ONE_Q, 32'h7fff_ffff));
    post(mk(rsi_pkg::OP_SHADOW, 0, 0, 0, ONE_Q, 32'h7fff_ffff));
    post(mk(rsi_pkg::OP_NEAREST, 0, ONE_Q, 0, 0, 32'h7fff_ffff));
    post(mk(rsi_pkg::OP_NEAREST, 0, 0, 0, ONE_Q, 32'h8000_0000));
    post(mk(rsi_pkg::OP_LOAD_NORMAL, 1, 0, ONE_Q, ONE_Q, 0));
    post(mk(rsi_pkg::OP_LOAD_SIZE, 1, -ONE_Q, 0, 0, 0));
    post(mk(rsi_pkg::OP_NEAREST, 0, 0, 0, ONE_Q, 32'h7fff_ffff));
    post(mk(OP_SPARE_6, 3, 1, 2, 3, 4));
    post(mk(OP_SPARE_7, 15, -1, -1, -1, -1));
    post(mk(rsi_pkg::OP_SET_ORIGIN, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0));
    post(mk(rsi_pkg::OP_SHADOW, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h7fff_ffff));
    post(mk(rsi_pkg::OP_NEAREST, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 6554));
    post(mk(rsi_pkg::OP_SET_ORIGIN, 0, 0, 0, 0, 0));
    set_count(0);
    post(mk(rsi_pkg::OP_NEAREST, 0, 0, 0, ONE_Q, 1234));
    post(mk(rsi_pkg::OP_SHADOW, 0, 0, 0, ONE_Q, 1234));

    // fill the whole table before any wider scan
    wait_idle();
    for (int s = 0; s < rsi_pkg::MAX_SQUARES; s++) random_square(s);
    post(mk(rsi_pkg::OP_SET_ORIGIN, 0, near_val(1 << 18), near_val(1 << 18),
            near_val(1 << 18), 0));

    k = 0;
    while (sent < TOTAL_ITEMS) begin
      case (k)
        0: n = 16;
        1: n = 31;
        2: n = 1;
        3: n = 0;
        default: n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
      endcase
      set_count(n);
      calm = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < ((n > 4) ? 6 : 30); j++) begin
        case ($urandom_range(0, 9))
          0, 1: random_square($urandom_range(0, rsi_pkg::MAX_SQUARES - 1));
          2: post(mk(rsi_pkg::OP_SET_ORIGIN, $urandom, near_val(1 << 18), near_val(1 << 18),
                     near_val(1 << 18), $urandom));
          3: post(mk($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, $urandom, $urandom,
                     $urandom, $urandom, $urandom));
          default: random_trace(n > rsi_pkg::MAX_SQUARES ? rsi_pkg::MAX_SQUARES : n);
        endcase
      end
      k++;
    end
    wait_idle();
    if (errors == 0 && hit_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
